[sv/tal_pkg.sv]
// Shared types and constants for the toy ALU loop executor.
// No dependencies; every other file in sv/ refers to this package.
package tal_pkg;

  localparam int REG_COUNT_DEFAULT = 32;
  localparam int DATA_BITS_DEFAULT = 16;

  localparam int MODE_W    = 3;
  localparam int REG_IDX_W = 5;
  localparam int IMM_W     = 16;
  localparam int COUNT_W   = 16;
  localparam int RESULT_W  = 16;
  localparam int FAULT_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_LOAD = 3'd4,
    MODE_LOOP = 3'd5,
    MODE_LEND = 3'd6,
    MODE_NOP  = 3'd7
  } mode_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_DIV_ZERO  = 2'd1,
    FAULT_LOOP_ZERO = 2'd2
  } fault_t;

  // controller -> datapath
  typedef struct packed {
    logic ready;
    logic capture;
    logic exec;
    logic div_start;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_needed;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

[sv/tal_instr_if.sv]
// Instruction channel: valid/ready handshake with the decoded instruction fields.
// Depends on tal_pkg.
interface tal_instr_if;
  logic                            valid;
  logic                            ready;
  tal_pkg::mode_t                  mode;
  logic [tal_pkg::REG_IDX_W-1:0]   dest_reg;
  logic [tal_pkg::REG_IDX_W-1:0]   src_reg;
  logic [tal_pkg::IMM_W-1:0]       imm_value;
  logic                            use_imm;

  modport source(output valid, mode, dest_reg, src_reg, imm_value, use_imm, input ready);
  modport sink(input valid, mode, dest_reg, src_reg, imm_value, use_imm, output ready);
endinterface

[sv/tal_result_if.sv]
// Result channel: valid/ready handshake with the per-instruction report.
// Depends on tal_pkg.
interface tal_result_if;
  logic                           valid;
  logic                           ready;
  logic [tal_pkg::RESULT_W-1:0]   alu_result;
  logic [tal_pkg::COUNT_W-1:0]    next_count;
  logic                           looping;
  tal_pkg::fault_t                fault;

  modport source(output valid, alu_result, next_count, looping, fault, input ready);
  modport sink(input valid, alu_result, next_count, looping, fault, output ready);
endinterface

[sv/toy_alu_loop_executor.sv]
// Toy ALU loop executor: one instruction at a time; the result is registered after
// capture, register read, execute and commit, with DIV also running the iterative
// divider (one quotient bit per cycle) unless its divisor is zero. Next instruction is
// taken the cycle after commit; commit itself waits while the result is held off.
// Synchronous active-high reset clears the counter, the loop state, the
// register-file valid bits (all registers read zero) and the output valid.
module toy_alu_loop_executor #(
  parameter int REG_COUNT = tal_pkg::REG_COUNT_DEFAULT,
  parameter int DATA_BITS = tal_pkg::DATA_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  tal_instr_if.sink    instr,
  tal_result_if.source result
);

  tal_pkg::cmd_t    cmd;
  tal_pkg::status_t status;

  // no transfer is taken while reset is held
  assign instr.ready = cmd.ready && !rst;

  tal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (instr.valid),
    .status   (status),
    .cmd      (cmd)
  );

  tal_datapath #(
    .REG_COUNT(REG_COUNT),
    .DATA_BITS(DATA_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .mode      (instr.mode),
    .dest_reg  (instr.dest_reg),
    .src_reg   (instr.src_reg),
    .imm_value (instr.imm_value),
    .use_imm   (instr.use_imm),
    .result    (result)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    instr.valid && instr.ready |=> !instr.ready)
    else $error("instruction accepted while another is in progress");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result.valid)
    else $error("committed result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result.valid || result.ready))
    else $error("result register overwritten before transfer");

endmodule

[sv/tal_regfile.sv]
// Register file: one write port, two registered read ports, per-entry valid bits.
// Depends on tal_pkg. Out-of-range indices read as zero and ignore writes.
module tal_regfile #(
  parameter int REG_COUNT = tal_pkg::REG_COUNT_DEFAULT,
  parameter int DATA_BITS = tal_pkg::DATA_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [tal_pkg::REG_IDX_W-1:0]   waddr,
  input  logic [DATA_BITS-1:0]            wdata,
  input  logic [tal_pkg::REG_IDX_W-1:0]   raddr_a,
  input  logic [tal_pkg::REG_IDX_W-1:0]   raddr_b,
  output logic [DATA_BITS-1:0]            rdata_a,
  output logic [DATA_BITS-1:0]            rdata_b
);

  // only 2**REG_IDX_W entries are reachable through the index fields
  localparam int REACH = 1 << tal_pkg::REG_IDX_W;
  localparam int DEPTH = (REG_COUNT < REACH) ? REG_COUNT : REACH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = tal_pkg::REG_IDX_W + 2;

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid;
  logic [DATA_BITS-1:0] q_a;
  logic [DATA_BITS-1:0] q_b;
  logic                 hit_a;
  logic                 hit_b;
  logic                 w_in;
  logic                 a_in;
  logic                 b_in;

  assign w_in = CW'(waddr)   < CW'(REG_COUNT);
  assign a_in = CW'(raddr_a) < CW'(REG_COUNT);
  assign b_in = CW'(raddr_b) < CW'(REG_COUNT);

  always_ff @(posedge clk) begin
    if (we && w_in) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    q_a <= mem[raddr_a[AW-1:0]];
    q_b <= mem[raddr_b[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit_a <= 1'b0;
      hit_b <= 1'b0;
    end else begin
      if (we && w_in) begin
        valid[waddr[AW-1:0]] <= 1'b1;
      end
      hit_a <= a_in && valid[raddr_a[AW-1:0]];
      hit_b <= b_in && valid[raddr_b[AW-1:0]];
    end
  end

  assign rdata_a = hit_a ? q_a : '0;
  assign rdata_b = hit_b ? q_b : '0;

endmodule

[sv/tal_divider.sv]
// Restoring divider, one quotient bit per cycle while busy.
// Depends on tal_pkg for the default width. Divisor must be non-zero.
module tal_divider #(
  parameter int DATA_BITS = tal_pkg::DATA_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DATA_BITS-1:0] dividend,
  input  logic [DATA_BITS-1:0] divisor,
  output logic                 busy,
  output logic [DATA_BITS-1:0] quotient
);

  localparam int CW = $clog2(DATA_BITS + 1);

  logic [DATA_BITS:0]   rem;
  logic [DATA_BITS-1:0] quo;
  logic [DATA_BITS-1:0] dvs;
  logic [CW-1:0]        cnt;
  logic [DATA_BITS:0]   shifted;
  logic [DATA_BITS:0]   diff;

  assign shifted = {rem[DATA_BITS-1:0], quo[DATA_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (diff[DATA_BITS]) begin
        rem <= shifted;
        quo <= {quo[DATA_BITS-2:0], 1'b0};
      end else begin
        rem <= diff;
        quo <= {quo[DATA_BITS-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DATA_BITS);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

endmodule

[sv/tal_datapath.sv]
// Datapath: instruction capture, register file, ALU, divider, loop state and
// the result output register. Depends on tal_pkg, tal_regfile, tal_divider.
module tal_datapath #(
  parameter int REG_COUNT = tal_pkg::REG_COUNT_DEFAULT,
  parameter int DATA_BITS = tal_pkg::DATA_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tal_pkg::cmd_t                   cmd,
  output tal_pkg::status_t                status,
  input  tal_pkg::mode_t                  mode,
  input  logic [tal_pkg::REG_IDX_W-1:0]   dest_reg,
  input  logic [tal_pkg::REG_IDX_W-1:0]   src_reg,
  input  logic [tal_pkg::IMM_W-1:0]       imm_value,
  input  logic                            use_imm,
  tal_result_if.source                    result
);

  localparam int CNTW = tal_pkg::COUNT_W;

  tal_pkg::mode_t                  mode_q;
  logic [tal_pkg::REG_IDX_W-1:0]   dest_q;
  logic [tal_pkg::REG_IDX_W-1:0]   src_q;
  logic [tal_pkg::IMM_W-1:0]       imm_q;
  logic                            use_imm_q;

  logic [DATA_BITS-1:0] rd_a;
  logic [DATA_BITS-1:0] rd_b;
  logic [DATA_BITS-1:0] op_b;
  logic                 b_zero;
  logic [DATA_BITS-1:0] arith;
  logic [DATA_BITS-1:0] quotient;
  logic                 div_busy;

  logic [CNTW-1:0] instr_count;
  logic            loop_active;
  logic [CNTW-1:0] loop_begin;
  logic [CNTW-1:0] loop_remaining;

  logic [DATA_BITS-1:0] res_next;
  tal_pkg::fault_t      fault_next;
  logic [CNTW-1:0]      count_next;
  logic                 active_next;
  logic [CNTW-1:0]      begin_next;
  logic [CNTW-1:0]      remaining_next;
  logic [CNTW-1:0]      count_inc;
  logic [CNTW-1:0]      rem_dec;
  logic [CNTW-1:0]      loop_cnt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q    <= mode;
      dest_q    <= dest_reg;
      src_q     <= src_reg;
      imm_q     <= imm_value;
      use_imm_q <= use_imm;
    end
  end

  tal_regfile #(
    .REG_COUNT(REG_COUNT),
    .DATA_BITS(DATA_BITS)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .we      (cmd.commit && (mode_q == tal_pkg::MODE_LOAD)),
    .waddr   (dest_q),
    .wdata   (DATA_BITS'(imm_q)),
    .raddr_a (dest_q),
    .raddr_b (src_q),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign op_b   = use_imm_q ? DATA_BITS'(imm_q) : rd_b;
  assign b_zero = (op_b == '0);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (mode_q)
        tal_pkg::MODE_ADD: arith <= rd_a + op_b;
        tal_pkg::MODE_SUB: arith <= rd_a - op_b;
        tal_pkg::MODE_MUL: arith <= rd_a * op_b;
        default:           arith <= '0;
      endcase
    end
  end

  tal_divider #(
    .DATA_BITS(DATA_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rd_a),
    .divisor  (op_b),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign status.div_needed = (mode_q == tal_pkg::MODE_DIV) && !b_zero;
  assign status.div_busy   = div_busy;
  assign status.out_free   = !result.valid || result.ready;

  assign count_inc = instr_count + CNTW'(1);
  assign rem_dec   = loop_remaining - CNTW'(1);
  assign loop_cnt  = use_imm_q ? CNTW'(imm_q) : CNTW'(rd_a);

  always_comb begin
    res_next       = '0;
    fault_next     = tal_pkg::FAULT_NONE;
    count_next     = count_inc;
    active_next    = loop_active;
    begin_next     = loop_begin;
    remaining_next = loop_remaining;
    case (mode_q) inside
      tal_pkg::MODE_ADD, tal_pkg::MODE_SUB, tal_pkg::MODE_MUL: begin
        res_next = arith;
      end
      tal_pkg::MODE_DIV: begin
        if (b_zero) begin
          fault_next = tal_pkg::FAULT_DIV_ZERO;
        end else begin
          res_next = quotient;
        end
      end
      tal_pkg::MODE_LOOP: begin
        if (!loop_active) begin
          // zero test is on the full register value, before narrowing
          if (!use_imm_q && (rd_a == '0)) begin
            fault_next = tal_pkg::FAULT_LOOP_ZERO;
          end else begin
            remaining_next = loop_cnt;
            begin_next     = instr_count;
            active_next    = 1'b1;
          end
        end
      end
      tal_pkg::MODE_LEND: begin
        if (loop_active) begin
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            active_next = 1'b0;
            begin_next  = '0;
          end else begin
            count_next = loop_begin;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      instr_count    <= '0;
      loop_active    <= 1'b0;
      loop_begin     <= '0;
      loop_remaining <= '0;
      result.valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        instr_count    <= count_next;
        loop_active    <= active_next;
        loop_begin     <= begin_next;
        loop_remaining <= remaining_next;
        result.valid   <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.alu_result <= tal_pkg::RESULT_W'(res_next);
      result.next_count <= count_next;
      result.looping    <= active_next;
      result.fault      <= fault_next;
    end
  end

endmodule

[sv/tal_ctrl.sv]
// Controller state machine: sequences capture, read, execute, divide and commit.
// Depends on tal_pkg for the command and status structs.
module tal_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tal_pkg::status_t status,
  output tal_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.div_needed) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to be free before committing
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sim/toy_alu_loop_executor_test.sv]
// Self-checking testbench for toy_alu_loop_executor: ALU results, instruction counter,
// loop state and faults are predicted per transfer and checked against each report.
// Depends on tal_pkg, tal_instr_if and tal_result_if from the RTL.
module toy_alu_loop_executor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tal_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_TAIL    = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 500;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    mode_t                mode;
    logic [REG_IDX_W-1:0] dest;
    logic [REG_IDX_W-1:0] src;
    logic [IMM_W-1:0]     imm;
    logic                 use_imm;
  } instr_t;

  typedef struct packed {
    logic [RESULT_W-1:0] alu_result;
    logic [COUNT_W-1:0]  next_count;
    logic                looping;
    fault_t              fault;
  } report_t;

  class alu_loop_tracker;
    logic [RESULT_W-1:0] regs [REG_COUNT_DEFAULT];
    logic [COUNT_W-1:0]  count;
    bit                  loop_on;
    logic [COUNT_W-1:0]  loop_head;
    logic [COUNT_W-1:0]  loop_left;
    report_t             pending[$];
    int errors, issued, checked, div_faults, zero_faults, loops_closed;

    function new();
      foreach (regs[i]) regs[i] = '0;
      count      = '0;
      loop_on    = 1'b0;
      loop_head  = '0;
      loop_left  = '0;
    endfunction

    // predict the report for an instruction accepted by the block
    function void note_issued(instr_t it);
      logic [RESULT_W-1:0] a, b;
      report_t exp;
      bit advance;
      a = regs[it.dest];
      b = it.use_imm ? it.imm : regs[it.src];
      exp.alu_result = '0;
      exp.fault = FAULT_NONE;
      advance = 1'b1;
      case (it.mode)
        MODE_ADD: exp.alu_result = a + b;
        MODE_SUB: exp.alu_result = a - b;
        MODE_MUL: exp.alu_result = a * b;
        MODE_DIV: begin
          if (b == '0) begin
            exp.fault = FAULT_DIV_ZERO;
            div_faults++;
          end else begin
            exp.alu_result = a / b;
          end
        end
        MODE_LOAD: regs[it.dest] = it.imm;
        MODE_LOOP: begin
          if (!loop_on) begin
            if (!it.use_imm && a == '0) begin
              exp.fault = FAULT_LOOP_ZERO;
              zero_faults++;
            end else begin
              loop_left  = it.use_imm ? it.imm : a;
              loop_head  = count;
              loop_on    = 1'b1;
            end
          end
        end
        MODE_LEND: begin
          if (loop_on) begin
            advance = 1'b0;
            loop_left = loop_left - 1'b1;
            if (loop_left == '0) begin
              loop_on    = 1'b0;
              loop_head  = '0;
              count      = count + 1'b1;
              loops_closed++;
            end else begin
              count = loop_head;
            end
          end
        end
        default: ;
      endcase
      if (advance) count = count + 1'b1;
      exp.next_count = count;
      exp.looping    = loop_on;
      pending.push_back(exp);
      issued++;
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_report(report_t got);
      report_t exp;
      if (pending.size() == 0) begin
        $display("%0t: report with nothing outstanding, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      compare("alu_result", 32'(exp.alu_result), 32'(got.alu_result));
      compare("next_count", 32'(exp.next_count), 32'(got.next_count));
      compare("looping", 32'(exp.looping), 32'(got.looping));
      compare("fault", 32'(exp.fault), 32'(got.fault));
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  bit   held;
  int   cycles;

  alu_loop_tracker tracker = new();
  mode_t arith_ops[4] = '{MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV};

  tal_instr_if  instr_ch();
  tal_result_if report_ch();

  toy_alu_loop_executor dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (report_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles,
               tracker.pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin : report_monitor
    report_t got;
    if (!rst && report_ch.valid && report_ch.ready) begin
      got.alu_result = report_ch.alu_result;
      got.next_count = report_ch.next_count;
      got.looping    = report_ch.looping;
      got.fault      = report_ch.fault;
      tracker.check_report(got);
    end
  end

  // result side: random back-pressure plus one long hold so the block backs up
  initial begin
    report_ch.ready = 1'b0;
    forever begin
      report_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!held && tracker.issued >= HOLD_AFTER) begin
        held = 1'b1;
        report_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm) begin
        report_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  function automatic instr_t make_instr(mode_t m, int dest, int src, int imm, bit use_imm);
    instr_t it;
    it.mode    = m;
    it.dest    = REG_IDX_W'(dest);
    it.src     = REG_IDX_W'(src);
    it.imm     = IMM_W'(imm);
    it.use_imm = use_imm;
    return it;
  endfunction

  task automatic send_instr(instr_t it);
    instr_ch.valid     <= 1'b1;
    instr_ch.mode      <= it.mode;
    instr_ch.dest_reg  <= it.dest;
    instr_ch.src_reg   <= it.src;
    instr_ch.imm_value <= it.imm;
    instr_ch.use_imm   <= it.use_imm;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    tracker.note_issued(it);
    if (!calm && $urandom_range(99) < 15) begin
      instr_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // mostly well-formed loops with random bodies; a share of stray loop ends
  function automatic instr_t draw_instr();
    instr_t it;
    int roll;
    it = make_instr(MODE_NOP, $urandom_range(31), $urandom_range(31),
                    $urandom_range(65535), 1'($urandom_range(1)));
    roll = $urandom_range(99);
    if (roll < 40) begin
      it.mode = arith_ops[$urandom_range(3)];
      if ($urandom_range(9) == 0) it.imm = '0;
    end else if (roll < 55) begin
      it.mode = MODE_LOAD;
      if ($urandom_range(1)) it.imm = IMM_W'($urandom_range(12));
    end else if (roll < 62) begin
      it.mode = MODE_NOP;
    end else if (tracker.loop_on) begin
      // a loop start here is ignored by the block
      it.mode = (roll < 72) ? MODE_LOOP : MODE_LEND;
    end else if (roll < 85) begin
      it.mode = MODE_LOOP;
      if (!it.use_imm && tracker.regs[it.dest] > 12) it.use_imm = 1'b1;
      if (it.use_imm) it.imm = IMM_W'($urandom_range(1, 12));
    end else begin
      it.mode = MODE_LEND;
    end
    return it;
  endfunction

  initial begin
    instr_ch.valid     = 1'b0;
    instr_ch.mode      = MODE_NOP;
    instr_ch.dest_reg  = '0;
    instr_ch.src_reg   = '0;
    instr_ch.imm_value = '0;
    instr_ch.use_imm   = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: operand extremes, divide by zero, loop corner cases
    send_instr(make_instr(MODE_ADD, 0, 0, 0, 1));
    send_instr(make_instr(MODE_LOAD, 31, 0, 16'hFFFF, 1));
    send_instr(make_instr(MODE_LOAD, 1, 31, 16'h0001, 0));
    send_instr(make_instr(MODE_ADD, 31, 0, 1, 1));
    send_instr(make_instr(MODE_SUB, 0, 1, 0, 0));
    send_instr(make_instr(MODE_MUL, 31, 31, 0, 0));
    send_instr(make_instr(MODE_MUL, 31, 0, 16'hFFFF, 1));
    send_instr(make_instr(MODE_DIV, 31, 0, 0, 1));
    send_instr(make_instr(MODE_DIV, 31, 2, 0, 0));
    send_instr(make_instr(MODE_DIV, 31, 1, 0, 0));
    send_instr(make_instr(MODE_DIV, 1, 0, 16'hFFFF, 1));
    send_instr(make_instr(MODE_NOP, 31, 31, 16'hFFFF, 1));
    send_instr(make_instr(MODE_LEND, 0, 0, 0, 0));
    send_instr(make_instr(MODE_LOOP, 2, 0, 7, 0));
    send_instr(make_instr(MODE_LOAD, 2, 0, 2, 1));
    send_instr(make_instr(MODE_LOOP, 2, 0, 0, 0));
    send_instr(make_instr(MODE_LOOP, 0, 0, 5, 1));
    send_instr(make_instr(MODE_ADD, 1, 0, 16'h8000, 1));
    send_instr(make_instr(MODE_LEND, 0, 0, 0, 0));
    send_instr(make_instr(MODE_LEND, 0, 0, 0, 0));
    send_instr(make_instr(MODE_LOOP, 0, 0, 1, 1));
    send_instr(make_instr(MODE_LEND, 0, 0, 0, 0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
      send_instr(draw_instr());
    end

    // close any open loop, then a zero immediate count: first loop end wraps, loop stays open
    while (tracker.loop_on) send_instr(make_instr(MODE_LEND, 0, 0, 0, 0));
    send_instr(make_instr(MODE_LOOP, 0, 0, 0, 1));
    send_instr(make_instr(MODE_LEND, 0, 0, 0, 0));
    send_instr(make_instr(MODE_NOP, 0, 0, 0, 0));
    instr_ch.valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d instructions checked, %0d loops closed", tracker.checked,
             tracker.loops_closed);
    $display("faults: %0d divide by zero, %0d zero register count; long result hold %0s",
             tracker.div_faults, tracker.zero_faults, held ? "done" : "missed");
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
